### hdl/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types, codes and helper functions for the event threshold and
// suppress block.
// ----------------------------------------------------------------------------
package ets_pkg;

  // default table geometry
  localparam int DEF_SETS = 64;
  localparam int DEF_WAYS = 4;

  // field widths
  localparam int ADDR_W = 32;
  localparam int CNT_W  = 16;
  localparam int TIME_W = 32;
  localparam int REG_W  = 3;
  localparam int DATA_W = 32;
  localparam int DEC_W  = 2;

  // thresholding modes
  localparam logic [1:0] THR_OFF    = 2'd0;
  localparam logic [1:0] THR_LIMIT  = 2'd1;
  localparam logic [1:0] THR_THRESH = 2'd2;
  localparam logic [1:0] THR_BOTH   = 2'd3;

  // suppression modes (the unused code behaves as off)
  localparam logic [1:0] SUP_OFF      = 2'd0;
  localparam logic [1:0] SUP_MATCH    = 2'd1;
  localparam logic [1:0] SUP_MISMATCH = 2'd2;

  // decision codes
  localparam logic [DEC_W-1:0] DEC_NONE  = 2'd0;
  localparam logic [DEC_W-1:0] DEC_SUPP  = 2'd1;
  localparam logic [DEC_W-1:0] DEC_LOG   = 2'd2;
  localparam logic [DEC_W-1:0] DEC_BLOCK = 2'd3;

  // register indexes
  localparam logic [REG_W-1:0] REG_THR_MODE      = 3'd0;
  localparam logic [REG_W-1:0] REG_THR_TRACK_DST = 3'd1;
  localparam logic [REG_W-1:0] REG_THR_COUNT     = 3'd2;
  localparam logic [REG_W-1:0] REG_THR_WINDOW    = 3'd3;
  localparam logic [REG_W-1:0] REG_SUP_MODE      = 3'd4;
  localparam logic [REG_W-1:0] REG_SUP_TRACK_DST = 3'd5;
  localparam logic [REG_W-1:0] REG_SUP_ADDR      = 3'd6;
  localparam logic [REG_W-1:0] REG_SUP_MASK      = 3'd7;

  // configuration register set
  typedef struct packed {
    logic [1:0]        thr_mode;
    logic              thr_track_dst;
    logic [CNT_W-1:0]  thr_count;
    logic [TIME_W-1:0] thr_window;
    logic [1:0]        sup_mode;
    logic              sup_track_dst;
    logic [ADDR_W-1:0] sup_addr;
    logic [ADDR_W-1:0] sup_mask;
  } ets_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the event
    logic rd;    // read the set row
    logic upd;   // decide, write back, present result
  } ets_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_UPDATE
  } ets_state_t;

  function automatic int clog2_min1(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic bit is_pow2(input int n);
    return ((n & (n - 1)) == 0);
  endfunction

  // byte fold of the tracked address
  function automatic logic [ADDR_W-1:0] fold_hash(input logic [ADDR_W-1:0] a);
    return a ^ (a >> 8) ^ (a >> 16) ^ (a >> 24);
  endfunction

endpackage

### hdl/ets_ram.sv
// ----------------------------------------------------------------------------
// ets_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ets_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/ets_cfg.sv
// ----------------------------------------------------------------------------
// ets_cfg
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module ets_cfg
  import ets_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [REG_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output ets_cfg_t          cfg
);

  ets_cfg_t cfg_r;
  ets_cfg_t cfg_nxt;

  // always able to take a write
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register select
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_THR_MODE:      cfg_nxt.thr_mode      = cfg_data[1:0];
        REG_THR_TRACK_DST: cfg_nxt.thr_track_dst = cfg_data[0];
        REG_THR_COUNT:     cfg_nxt.thr_count     = cfg_data[CNT_W-1:0];
        REG_THR_WINDOW:    cfg_nxt.thr_window    = cfg_data[TIME_W-1:0];
        REG_SUP_MODE:      cfg_nxt.sup_mode      = cfg_data[1:0];
        REG_SUP_TRACK_DST: cfg_nxt.sup_track_dst = cfg_data[0];
        REG_SUP_ADDR:      cfg_nxt.sup_addr      = cfg_data[ADDR_W-1:0];
        REG_SUP_MASK:      cfg_nxt.sup_mask      = cfg_data[ADDR_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr_mode      <= THR_OFF;
      cfg_r.thr_track_dst <= 1'b0;
      cfg_r.thr_count     <= CNT_W'(1);
      cfg_r.thr_window    <= TIME_W'(60);
      cfg_r.sup_mode      <= SUP_OFF;
      cfg_r.sup_track_dst <= 1'b0;
      cfg_r.sup_addr      <= '0;
      cfg_r.sup_mask      <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hdl/ets_ctrl.sv
// ----------------------------------------------------------------------------
// ets_ctrl
// Event sequencer: capture, optional set index stage, decide and write back.
// ----------------------------------------------------------------------------
module ets_ctrl
  import ets_pkg::*;
#(
  parameter int SETS = DEF_SETS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output ets_cmd_t cmd
);

  // power of two set counts index straight from the event
  localparam bit FAST = is_pow2(SETS);

  ets_state_t state_r;
  ets_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (FAST) begin
            cmd.rd    = 1'b1;
            state_nxt = ST_UPDATE;
          end else begin
            state_nxt = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### hdl/ets_dp.sv
// ----------------------------------------------------------------------------
// ets_dp
// Datapath: suppression filter, set index, tracking table row read, way
// match, LRU victim choice, window test and row write back.
// ----------------------------------------------------------------------------
module ets_dp
  import ets_pkg::*;
#(
  parameter int SETS = DEF_SETS,
  parameter int WAYS = DEF_WAYS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ets_cfg_t          cfg,
  input  ets_cmd_t          cmd,
  input  logic [ADDR_W-1:0] in_src_addr,
  input  logic [ADDR_W-1:0] in_dst_addr,
  input  logic [TIME_W-1:0] in_now_seconds,
  output logic              out_valid,
  output logic              out_log_event,
  output logic [DEC_W-1:0]  out_decision
);

  localparam int  SET_W  = clog2_min1(SETS);
  localparam int  WAY_W  = clog2_min1(WAYS);
  localparam int  AGE_W  = clog2_min1(WAYS);
  localparam int  OLD_W  = AGE_W + 1;
  localparam int  ENT_W  = ADDR_W + CNT_W + TIME_W + AGE_W;
  localparam int  ROW_W  = WAYS * ENT_W;
  localparam bit  FAST   = is_pow2(SETS);
  localparam logic [ADDR_W-1:0] SETS_U = ADDR_W'(SETS);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] start;
    logic [AGE_W-1:0]  age;
  } entry_t;

  // event capture
  logic [ADDR_W-1:0] ta_in;
  logic [ADDR_W-1:0] sa_in;
  logic              sup_hit;
  logic              drop_in;
  logic [ADDR_W-1:0] ta_r;
  logic [TIME_W-1:0] now_r;
  logic              drop_r;

  assign ta_in   = cfg.thr_track_dst ? in_dst_addr : in_src_addr;
  assign sa_in   = cfg.sup_track_dst ? in_dst_addr : in_src_addr;
  assign sup_hit = ((sa_in & cfg.sup_mask) == cfg.sup_addr);
  assign drop_in = ((cfg.sup_mode == SUP_MATCH) && sup_hit) ||
                   ((cfg.sup_mode == SUP_MISMATCH) && !sup_hit);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ta_r   <= ta_in;
      now_r  <= in_now_seconds;
      drop_r <= drop_in;
    end
  end

  // set index
  logic [SET_W-1:0] rd_idx;

  if (FAST) begin : g_idx_mask
    assign rd_idx = SET_W'(fold_hash(ta_in) & (SETS_U - 1'b1));
  end else begin : g_idx_recip
    // floor(h / SETS) by reciprocal, one correction step on the remainder
    localparam logic [63:0] RECIP = (64'd1 << 32) / SETS;
    logic [ADDR_W-1:0] recip32;
    logic [63:0]       prod_r;
    logic [ADDR_W-1:0] h_r;
    logic [ADDR_W-1:0] q;
    logic [ADDR_W-1:0] rem;
    logic [ADDR_W-1:0] rem_c;

    assign recip32 = RECIP[ADDR_W-1:0];

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        prod_r <= fold_hash(ta_in) * recip32;
      end
    end

    assign h_r    = fold_hash(ta_r);
    assign q      = prod_r[63:32];
    assign rem    = h_r - ADDR_W'(q * SETS_U);
    assign rem_c  = (rem >= SETS_U) ? (rem - SETS_U) : rem;
    assign rd_idx = rem_c[SET_W-1:0];
  end

  // table row memory and valid bits
  logic [SET_W-1:0] widx_r;
  logic [WAYS-1:0]  vrow_r;
  logic [WAYS-1:0]  valid_r [SETS];
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] ram_wdata;
  logic             ram_we;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      widx_r <= rd_idx;
      vrow_r <= valid_r[rd_idx];
    end
  end

  ets_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_r),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // way match, victim choice and window test
  entry_t [WAYS-1:0] rd_row;
  entry_t [WAYS-1:0] wr_row;
  entry_t            sel;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic              free_found;
  logic [WAY_W-1:0]  free_way;
  logic [AGE_W-1:0]  best_age;
  logic [WAY_W-1:0]  old_way;
  logic [WAY_W-1:0]  way_sel;
  logic [OLD_W-1:0]  old_age;
  logic [CNT_W-1:0]  cnt_v;
  logic [TIME_W-1:0] start_v;
  logic [TIME_W-1:0] dt;
  logic              over;
  logic              logit;
  logic              skip;

  assign rd_row = ram_rdata;

  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    best_age   = '0;
    old_way    = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && vrow_r[w] && (rd_row[w].addr == ta_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!free_found && !vrow_r[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
      if (rd_row[w].age > best_age) begin
        best_age = rd_row[w].age;
        old_way  = WAY_W'(w);
      end
    end
    way_sel = hit ? hit_way : (free_found ? free_way : old_way);
  end

  assign sel = rd_row[way_sel];

  always_comb begin
    old_age = hit ? {1'b0, sel.age} : OLD_W'(WAYS);
    if (hit) begin
      cnt_v   = (sel.cnt == '1) ? sel.cnt : sel.cnt + 1'b1;
      start_v = sel.start;
    end else begin
      cnt_v   = CNT_W'(1);
      start_v = now_r;
    end
    dt    = now_r - start_v;
    over  = (dt > cfg.thr_window);
    logit = 1'b0;
    case (cfg.thr_mode)
      THR_LIMIT: begin
        if (over) begin
          start_v = now_r;
          cnt_v   = CNT_W'(1);
        end
        logit = (cnt_v <= cfg.thr_count);
      end
      THR_THRESH: begin
        if (over) begin
          start_v = now_r;
          cnt_v   = CNT_W'(1);
        end else if (cnt_v >= cfg.thr_count) begin
          cnt_v   = '0;
          start_v = now_r;
          logit   = 1'b1;
        end
      end
      THR_BOTH: begin
        if (over) begin
          start_v = now_r;
          cnt_v   = CNT_W'(1);
        end else begin
          logit = (cnt_v == cfg.thr_count);
        end
      end
      default: logit = 1'b0;
    endcase
    // a new entry always starts a fresh window
    if (!hit) begin
      cnt_v   = CNT_W'(1);
      start_v = now_r;
    end
  end

  // row write back with LRU ageing
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      wr_row[w] = rd_row[w];
      if (WAY_W'(w) == way_sel) begin
        wr_row[w].addr  = ta_r;
        wr_row[w].cnt   = cnt_v;
        wr_row[w].start = start_v;
        wr_row[w].age   = '0;
      end else if (vrow_r[w] && ({1'b0, rd_row[w].age} < old_age)) begin
        wr_row[w].age = rd_row[w].age + 1'b1;
      end
    end
  end

  assign skip      = drop_r || (cfg.thr_mode == THR_OFF);
  assign ram_we    = cmd.upd && !skip;
  assign ram_wdata = wr_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else if (ram_we) begin
      valid_r[widx_r][way_sel] <= 1'b1;
    end
  end

  // result register
  logic             out_valid_r;
  logic             out_log_r;
  logic [DEC_W-1:0] out_dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      if (drop_r) begin
        out_log_r <= 1'b0;
        out_dec_r <= DEC_SUPP;
      end else if (cfg.thr_mode == THR_OFF) begin
        out_log_r <= 1'b1;
        out_dec_r <= DEC_NONE;
      end else begin
        out_log_r <= logit;
        out_dec_r <= logit ? DEC_LOG : DEC_BLOCK;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_log_event = out_log_r;
  assign out_decision  = out_dec_r;

endmodule

### hdl/event_threshold_suppress.sv
// ----------------------------------------------------------------------------
// event_threshold_suppress
// Alert event filter: address suppression followed by one thresholding
// object with a per-address count and window in an LRU set-associative table.
// ----------------------------------------------------------------------------
//  channel   ports                                      handshake
//  event     in_src_addr, in_dst_addr, in_now_seconds   start && !busy
//  result    out_log_event, out_decision                out_valid, one cycle
//  config    cfg_index, cfg_data                        cfg_valid && cfg_ready
//
//  With SETS a power of two an event goes from capture to the update state;
//  otherwise a hash state forms the set index by the reciprocal multiply.
//  The sequence follows the table row memory: one read, then one write back
//  before the next event may read the same set.
//  The result is registered at the write back edge; busy is low when it shows.
//  Synchronous reset clears control state and all valid bits at once; no
//  clearing pass. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module event_threshold_suppress
  import ets_pkg::*;
#(
  parameter int SETS = DEF_SETS,
  parameter int WAYS = DEF_WAYS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ADDR_W-1:0] in_src_addr,
  input  logic [ADDR_W-1:0] in_dst_addr,
  input  logic [TIME_W-1:0] in_now_seconds,
  output logic              out_valid,
  output logic              out_log_event,
  output logic [DEC_W-1:0]  out_decision,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [REG_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  ets_cfg_t cfg;
  ets_cmd_t cmd;

  // configuration registers
  ets_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  ets_ctrl #(
    .SETS (SETS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath
  ets_dp #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .in_src_addr    (in_src_addr),
    .in_dst_addr    (in_dst_addr),
    .in_now_seconds (in_now_seconds),
    .out_valid      (out_valid),
    .out_log_event  (out_log_event),
    .out_decision   (out_decision)
  );

endmodule

### hdl/ets_checker.sv
// ----------------------------------------------------------------------------
// ets_checker
// Port level checks on event sequencing and result coding.
// ----------------------------------------------------------------------------
module ets_checker
  import ets_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic             out_log_event,
  input logic [DEC_W-1:0] out_decision
);

  // an accepted event makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after event transfer");

  // a result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result follows a busy phase
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding event");

  // log flag agrees with the decision code
  a_log_coding: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_log_event ==
                   ((out_decision == DEC_LOG) || (out_decision == DEC_NONE))))
    else $error("log flag disagrees with decision");

endmodule

bind event_threshold_suppress ets_checker u_ets_checker (.*);

### test/event_threshold_suppress_test.sv
// ----------------------------------------------------------------------------
// event_threshold_suppress_test
// Self-checking bench for the alert event filter. A clocked driver issues
// events from a backlog and a clocked monitor compares every result strobe
// with the verdict that a local predictor (own copy of the registers and the
// tracking table) worked out when the event was accepted. Directed events
// cover each mode and corner, then randomised phases over small address pools
// exercise hits, window expiry, wrap of time and LRU replacement, and a
// closing back to back burst on one address runs past its limit.
// ----------------------------------------------------------------------------
module event_threshold_suppress_test;
  import ets_pkg::*;

  localparam int SETS        = DEF_SETS;
  localparam int WAYS        = DEF_WAYS;
  localparam int ROWS        = SETS * WAYS;
  localparam int POOL        = 12;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 160;
  localparam int BURST_ITEMS = 24;
  localparam int CYCLE_LIMIT = 2000000;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  // unused suppression code, expected to behave as off
  localparam logic [1:0]       SUP_SPARE = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [TIME_W-1:0] now;
  } alert_t;

  typedef struct packed {
    logic             log_event;
    logic [DEC_W-1:0] decision;
  } verdict_t;

  typedef struct packed {
    logic [REG_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } reg_write_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  logic [ADDR_W-1:0] in_src_addr    = '0;
  logic [ADDR_W-1:0] in_dst_addr    = '0;
  logic [TIME_W-1:0] in_now_seconds = '0;
  logic              out_valid;
  logic              out_log_event;
  logic [DEC_W-1:0]  out_decision;
  logic              cfg_valid      = 1'b0;
  logic              cfg_ready;
  logic [REG_W-1:0]  cfg_index      = '0;
  logic [DATA_W-1:0] cfg_data       = '0;

  // predictor copy of the registers and tracking table
  ets_cfg_t          shadow;
  logic              row_valid [ROWS];
  logic [ADDR_W-1:0] row_addr  [ROWS];
  logic [CNT_W-1:0]  row_cnt   [ROWS];
  logic [TIME_W-1:0] row_start [ROWS];
  int unsigned       row_age   [ROWS];

  alert_t     alert_backlog[$];
  verdict_t   pending_verdicts[$];
  reg_write_t reg_backlog[$];
  alert_t     cur_alert;
  reg_write_t cur_reg;
  logic [ADDR_W-1:0] pool [POOL];

  int idle_left   = 0;
  int idle_pct    = 0;
  int posted      = 0;
  int answered    = 0;
  int regs_queued = 0;
  int regs_done   = 0;
  int mismatches  = 0;
  int cycle_count = 0;

  event_threshold_suppress #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_src_addr   (in_src_addr),
    .in_dst_addr   (in_dst_addr),
    .in_now_seconds(in_now_seconds),
    .out_valid     (out_valid),
    .out_log_event (out_log_event),
    .out_decision  (out_decision),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // byte fold of the tracked address, reduced to a set number
  function automatic int set_of_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] h;
    h = a ^ (a >> 8) ^ (a >> 16) ^ (a >> 24);
    return int'(h % SETS);
  endfunction

  // expected verdict for one accepted event, updating the table copy
  function automatic verdict_t judge_alert(input alert_t ev);
    logic [ADDR_W-1:0] sa, ta;
    logic [TIME_W-1:0] t0, dt;
    logic [CNT_W-1:0]  cnt;
    int                base, way, best;
    int unsigned       old_age;
    bit                hit, found, matched, logit;
    verdict_t          v;
    sa = shadow.sup_track_dst ? ev.dst : ev.src;
    ta = shadow.thr_track_dst ? ev.dst : ev.src;
    matched = ((sa & shadow.sup_mask) == shadow.sup_addr);
    if ((shadow.sup_mode == SUP_MATCH && matched) ||
        (shadow.sup_mode == SUP_MISMATCH && !matched)) begin
      v.log_event = 1'b0;
      v.decision  = DEC_SUPP;
      return v;
    end
    if (shadow.thr_mode == THR_OFF) begin
      v.log_event = 1'b1;
      v.decision  = DEC_NONE;
      return v;
    end
    base = set_of_addr(ta) * WAYS;
    hit  = 1'b0;
    way  = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && row_valid[base + w] && row_addr[base + w] == ta) begin
        hit = 1'b1;
        way = w;
      end
    end
    if (hit) begin
      old_age = row_age[base + way];
      cnt     = row_cnt[base + way];
      if (cnt != CNT_MAX) cnt++;
      t0 = row_start[base + way];
    end else begin
      // lowest free way, else the oldest one (lowest index on a tie)
      found = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
        if (!found && !row_valid[base + w]) begin
          found = 1'b1;
          way   = w;
        end
      end
      if (!found) begin
        best = 0;
        for (int w = 0; w < WAYS; w++) begin
          if (row_age[base + w] > best) begin
            best = row_age[base + w];
            way  = w;
          end
        end
      end
      old_age = WAYS;
      cnt     = 1;
      t0      = ev.now;
    end
    dt = ev.now - t0;
    case (shadow.thr_mode)
      THR_LIMIT: begin
        if (dt > shadow.thr_window) begin
          t0  = ev.now;
          cnt = 1;
        end
        logit = (cnt <= shadow.thr_count);
      end
      THR_THRESH: begin
        if (dt > shadow.thr_window) begin
          t0    = ev.now;
          cnt   = 1;
          logit = 1'b0;
        end else if (cnt >= shadow.thr_count) begin
          cnt   = 0;
          t0    = ev.now;
          logit = 1'b1;
        end else begin
          logit = 1'b0;
        end
      end
      default: begin
        if (dt > shadow.thr_window) begin
          t0    = ev.now;
          cnt   = 1;
          logit = 1'b0;
        end else begin
          logit = (cnt == shadow.thr_count);
        end
      end
    endcase
    // a fresh entry always starts its own window
    if (!hit) begin
      cnt = 1;
      t0  = ev.now;
    end
    row_valid[base + way] = 1'b1;
    row_addr[base + way]  = ta;
    row_cnt[base + way]   = cnt;
    row_start[base + way] = t0;
    for (int w = 0; w < WAYS; w++) begin
      if (w != way && row_valid[base + w] && row_age[base + w] < old_age)
        row_age[base + w]++;
    end
    row_age[base + way] = 0;
    v.log_event = logit;
    v.decision  = logit ? DEC_LOG : DEC_BLOCK;
    return v;
  endfunction

  // event driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_verdicts.push_back(judge_alert(cur_alert));
        if ($urandom_range(0, 99) < idle_pct) idle_left = $urandom_range(1, 6);
      end
      if (!start || !busy) begin
        if (idle_left > 0 || alert_backlog.size() == 0) begin
          if (idle_left > 0) idle_left--;
          start          <= 1'b0;
          in_src_addr    <= $urandom;
          in_dst_addr    <= $urandom;
          in_now_seconds <= $urandom;
        end else begin
          cur_alert       = alert_backlog.pop_front();
          start          <= 1'b1;
          in_src_addr    <= cur_alert.src;
          in_dst_addr    <= cur_alert.dst;
          in_now_seconds <= cur_alert.now;
        end
      end
    end
  end

  // register write driver, updates the shadow registers on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THR_MODE:      shadow.thr_mode      = cfg_data[1:0];
          REG_THR_TRACK_DST: shadow.thr_track_dst = cfg_data[0];
          REG_THR_COUNT:     shadow.thr_count     = cfg_data[CNT_W-1:0];
          REG_THR_WINDOW:    shadow.thr_window    = cfg_data[TIME_W-1:0];
          REG_SUP_MODE:      shadow.sup_mode      = cfg_data[1:0];
          REG_SUP_TRACK_DST: shadow.sup_track_dst = cfg_data[0];
          REG_SUP_ADDR:      shadow.sup_addr      = cfg_data[ADDR_W-1:0];
          REG_SUP_MASK:      shadow.sup_mask      = cfg_data[ADDR_W-1:0];
          default: ;
        endcase
        regs_done++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_backlog.size() != 0) begin
          cur_reg    = reg_backlog.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= cur_reg.idx;
          cfg_data  <= cur_reg.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        if (mismatches < 10)
          $display("cycle %0d: result log %0b decision %0d with nothing pending",
                   cycle_count, out_log_event, out_decision);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        answered++;
        if (out_log_event !== want.log_event || out_decision !== want.decision) begin
          if (mismatches < 10)
            $display("cycle %0d: expected log %0b decision %0d, got log %0b decision %0d",
                     cycle_count, want.log_event, want.decision,
                     out_log_event, out_decision);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic post_alert(input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
                            input logic [TIME_W-1:0] now);
    alert_t a;
    a.src = src;
    a.dst = dst;
    a.now = now;
    alert_backlog.push_back(a);
    posted++;
  endtask

  // narrow registers get random bits above their width, which must be ignored
  task automatic set_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] val,
                         input int width);
    reg_write_t w;
    w.idx  = idx;
    w.data = (width < DATA_W) ? (val | (DATA_W'($urandom) << width)) : val;
    reg_backlog.push_back(w);
    regs_queued++;
  endtask

  task automatic commit_regs();
    while (regs_done != regs_queued) @(posedge clk);
  endtask

  // every posted event answered, then a few quiet cycles
  task automatic drain_alerts();
    while (answered != posted) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // address landing in set s (the set is the low six bits of the byte fold)
  function automatic logic [ADDR_W-1:0] addr_in_set(input int s, input logic [15:0] hi,
                                                    input bit keep_hi);
    logic [7:0] b3, b2, b1, b0;
    b1       = 8'($urandom);
    {b3, b2} = keep_hi ? hi : 16'($urandom);
    b0       = {2'($urandom), 6'(s) ^ b1[5:0] ^ b2[5:0] ^ b3[5:0]};
    return {b3, b2, b1, b0};
  endfunction

  // half the pool crowds one set so that replacement happens
  task automatic build_pool();
    logic [15:0] net;
    int          crowded;
    net     = 16'($urandom);
    crowded = $urandom_range(0, SETS - 1);
    for (int i = 0; i < POOL; i++)
      pool[i] = addr_in_set((i < POOL / 2) ? crowded : $urandom_range(0, SETS - 1),
                            net, i[0]);
  endtask

  // random register settings for one phase, extremes forced on some phases
  task automatic program_phase(input int p, output logic [TIME_W-1:0] win);
    logic [1:0]        tm;
    logic [CNT_W-1:0]  lim;
    logic [ADDR_W-1:0] mask, addr;
    tm = (p == 0) ? THR_OFF : 2'(1 + p % 3);
    case (p)
      1:       win = '0;
      2:       win = '1;
      default: begin
        case ($urandom_range(0, 3))
          0:       win = '0;
          1:       win = $urandom_range(1, 4);
          2:       win = $urandom_range(5, 30);
          default: win = $urandom;
        endcase
      end
    endcase
    case (p)
      3:       lim = '0;
      4:       lim = CNT_MAX;
      5:       lim = 16'd1;
      default: lim = 16'($urandom_range(2, 6));
    endcase
    case ($urandom_range(0, 3))
      0:       mask = '1;
      1:       mask = '0;
      2:       mask = 32'hFFFF_0000;
      default: mask = $urandom;
    endcase
    addr = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom)
                                       : pool[$urandom_range(0, POOL - 1)] & mask;
    set_reg(REG_THR_MODE, tm, 2);
    set_reg(REG_THR_TRACK_DST, $urandom_range(0, 1), 1);
    set_reg(REG_THR_COUNT, lim, CNT_W);
    set_reg(REG_THR_WINDOW, win, TIME_W);
    set_reg(REG_SUP_MODE, 2'(p % 4), 2);
    set_reg(REG_SUP_TRACK_DST, $urandom_range(0, 1), 1);
    set_reg(REG_SUP_ADDR, addr, ADDR_W);
    set_reg(REG_SUP_MASK, mask, ADDR_W);
    commit_regs();
  endtask

  // mostly pool addresses and slowly moving time, with jumps past the window,
  // steps back and the odd fully random event
  task automatic post_random_alerts(input int n, input logic [TIME_W-1:0] win);
    logic [TIME_W-1:0] t;
    logic [ADDR_W-1:0] s, d;
    int                r;
    if ($urandom_range(0, 3) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 60);
    else t = $urandom;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 70) t += $urandom_range(0, 2);
      else if (r < 85) t += (win < 64) ? win + $urandom_range(0, 2) : $urandom_range(3, 64);
      else if (r < 93) t -= $urandom_range(1, 3);
      else t = $urandom;
      s = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL - 1)] : $urandom;
      d = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL - 1)] : $urandom;
      post_alert(s, d, t);
    end
  endtask

  initial begin
    logic [TIME_W-1:0] win;
    logic [ADDR_W-1:0] lru [5];
    logic [ADDR_W-1:0] hot;
    int                s;

    // power-on register values and an empty table
    shadow.thr_mode      = THR_OFF;
    shadow.thr_track_dst = 1'b0;
    shadow.thr_count     = 16'd1;
    shadow.thr_window    = 32'd60;
    shadow.sup_mode      = SUP_OFF;
    shadow.sup_track_dst = 1'b0;
    shadow.sup_addr      = '0;
    shadow.sup_mask      = '1;
    for (int i = 0; i < ROWS; i++) begin
      row_valid[i] = 1'b0;
      row_age[i]   = 0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 20;

    // reset settings: no object, no suppression, field extremes
    post_alert('0, '1, '0);
    post_alert('1, '0, '1);
    drain_alerts();

    // limit: count 2 in a 5 s window, expiry restarts the count
    set_reg(REG_THR_MODE, THR_LIMIT, 2);
    set_reg(REG_THR_COUNT, 16'd2, CNT_W);
    set_reg(REG_THR_WINDOW, 32'd5, TIME_W);
    commit_regs();
    post_alert(32'h0A00_0001, 32'h0, 32'd100);
    post_alert(32'h0A00_0001, 32'h0, 32'd101);
    post_alert(32'h0A00_0001, 32'h0, 32'd102);
    post_alert(32'h0A00_0001, 32'h0, 32'd108);
    post_alert(32'h0A00_0001, 32'h0, 32'd108);
    drain_alerts();

    // threshold on destination: third event logs and clears, late one blocks
    set_reg(REG_THR_MODE, THR_THRESH, 2);
    set_reg(REG_THR_TRACK_DST, 1'b1, 1);
    set_reg(REG_THR_COUNT, 16'd3, CNT_W);
    set_reg(REG_THR_WINDOW, 32'd10, TIME_W);
    commit_regs();
    post_alert(32'h0102_0304, 32'hC0A8_0001, 32'd50);
    post_alert(32'h0506_0708, 32'hC0A8_0001, 32'd51);
    post_alert(32'h090A_0B0C, 32'hC0A8_0001, 32'd52);
    post_alert(32'h0D0E_0F10, 32'hC0A8_0001, 32'd53);
    post_alert(32'h1112_1314, 32'hC0A8_0001, 32'd80);
    drain_alerts();

    // threshold plus limit across the wrap of time
    set_reg(REG_THR_MODE, THR_BOTH, 2);
    set_reg(REG_THR_TRACK_DST, 1'b0, 1);
    set_reg(REG_THR_COUNT, 16'd2, CNT_W);
    set_reg(REG_THR_WINDOW, 32'd4, TIME_W);
    commit_regs();
    post_alert(32'hAC10_2030, 32'h0, 32'hFFFF_FFFE);
    post_alert(32'hAC10_2030, 32'h0, 32'd1);
    post_alert(32'hAC10_2030, 32'h0, 32'd2);
    post_alert(32'hAC10_2030, 32'h0, 32'd1000);
    drain_alerts();

    // suppression on match, on mismatch, and the spare code acting as off
    set_reg(REG_THR_MODE, THR_LIMIT, 2);
    set_reg(REG_THR_COUNT, CNT_MAX, CNT_W);
    set_reg(REG_THR_WINDOW, '1, TIME_W);
    set_reg(REG_SUP_MODE, SUP_MATCH, 2);
    set_reg(REG_SUP_TRACK_DST, 1'b1, 1);
    set_reg(REG_SUP_ADDR, 32'h0A0B_0000, ADDR_W);
    set_reg(REG_SUP_MASK, 32'hFFFF_0000, ADDR_W);
    commit_regs();
    post_alert(32'h1111_1111, 32'h0A0B_1234, 32'd5);
    post_alert(32'h1111_1111, 32'h0A0C_1234, 32'd6);
    drain_alerts();
    set_reg(REG_SUP_MODE, SUP_MISMATCH, 2);
    commit_regs();
    post_alert(32'h1111_1111, 32'h0A0B_1234, 32'd7);
    post_alert(32'h1111_1111, 32'h0A0C_1234, 32'd8);
    drain_alerts();
    set_reg(REG_SUP_MODE, SUP_SPARE, 2);
    commit_regs();
    post_alert(32'h1111_1111, 32'h0A0B_1234, 32'd9);
    drain_alerts();

    // five addresses in one set: refresh of one way, then eviction of the oldest
    set_reg(REG_SUP_MODE, SUP_OFF, 2);
    set_reg(REG_THR_COUNT, 16'd1, CNT_W);
    commit_regs();
    s = $urandom_range(0, SETS - 1);
    for (int i = 0; i < 5; i++) lru[i] = addr_in_set(s, 16'h0, 1'b0);
    for (int i = 0; i < 4; i++) post_alert(lru[i], 32'h0, 32'd20);
    post_alert(lru[0], 32'h0, 32'd21);
    post_alert(lru[4], 32'h0, 32'd22);
    post_alert(lru[1], 32'h0, 32'd23);
    drain_alerts();

    // random phases, the last one without idle cycles
    for (int p = 0; p < PHASES; p++) begin
      build_pool();
      program_phase(p, win);
      idle_pct = (p == PHASES - 1) ? 0 : ((p % 3 == 0) ? 5 : 35);
      post_random_alerts(PHASE_ITEMS, win);
      drain_alerts();
    end

    // one address hammered back to back past its limit, then stays blocked
    set_reg(REG_THR_MODE, THR_LIMIT, 2);
    set_reg(REG_THR_TRACK_DST, 1'b0, 1);
    set_reg(REG_THR_COUNT, 16'd8, CNT_W);
    set_reg(REG_THR_WINDOW, '1, TIME_W);
    set_reg(REG_SUP_MODE, SUP_OFF, 2);
    commit_regs();
    idle_pct = 0;
    hot = $urandom;
    repeat (BURST_ITEMS) post_alert(hot, $urandom, 32'd4242);
    while (answered != posted) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
